### hw/rtl/ecf_pkg.sv
// Shared types and constants for the equal-power crossfade timeline.
// Holds phase codes, register indexes, fade-curve coefficients and defaults.
// No dependencies.
`timescale 1ns / 1ps

package ecf_pkg;

  localparam int FRAME_BITS_DEF    = 48;
  localparam int PROGRESS_BITS_DEF = 16;
  localparam int DUR_W             = 32;
  localparam int REG_IDX_W         = 3;

  // Odd polynomial for sin(pi/2 * x), Q2.30 coefficients
  localparam logic [31:0] SIN_A1 = 32'd1686629713;
  localparam logic [31:0] SIN_A3 = 32'd693598668;
  localparam logic [31:0] SIN_A5 = 32'd85569305;
  localparam logic [31:0] SIN_A7 = 32'd5026995;

  localparam logic [16:0] GAIN_ONE = 17'd32768;

  typedef enum logic [1:0] {
    PH_OFF    = 2'd0,
    PH_BEFORE = 2'd1,
    PH_DURING = 2'd2,
    PH_AFTER  = 2'd3
  } phase_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_START    = 3'd0,
    REG_DURATION = 3'd1,
    REG_MODE     = 3'd2,
    REG_GAIN     = 3'd3,
    REG_OUT_LOW  = 3'd4,
    REG_OUT_MID  = 3'd5,
    REG_IN_LOW   = 3'd6,
    REG_IN_MID   = 3'd7
  } reg_idx_t;

  localparam logic [31:0] GAIN_PAIR_RST = 32'h8000_8000;

endpackage

### hw/rtl/ecf_sine.sv
// Five-stage pipelined quarter sine, sin(pi/2 * x), x in Q1.24, result Q1.15.
// Depends on ecf_pkg for the polynomial coefficients.
`timescale 1ns / 1ps

module ecf_sine (
  input  logic        clk,
  input  logic        en,
  input  logic [24:0] x,     // bit 24 set means x >= 1.0
  output logic [15:0] s
);
  import ecf_pkg::*;

  logic        big1, big2, big3, big4;
  logic [23:0] x1, x2, x3, x4;
  logic [23:0] y1, y2, y3;
  logic [31:0] t2, t3, t4;

  logic [47:0] xx;
  logic [55:0] m2, m3, m4, m5;
  logic [31:0] s_raw;
  logic [16:0] s_rnd;

  always_comb begin
    xx    = 48'(x[23:0]) * 48'(x[23:0]);
    m2    = 56'(y1) * 56'(SIN_A7);
    m3    = 56'(y2) * 56'(t2);
    m4    = 56'(y3) * 56'(t3);
    m5    = 56'(x4) * 56'(t4);
    s_raw = m5[55:24];
    s_rnd = 17'((33'(s_raw) + 33'd16384) >> 15);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1   <= x[23:0];
      big1 <= x[24];
      y1   <= xx[47:24];
      x2   <= x1;
      big2 <= big1;
      y2   <= y1;
      t2   <= SIN_A5 - m2[55:24];
      x3   <= x2;
      big3 <= big2;
      y3   <= y2;
      t3   <= SIN_A3 - m3[55:24];
      x4   <= x3;
      big4 <= big3;
      t4   <= SIN_A1 - m4[55:24];
      if (big4 || s_rnd > GAIN_ONE) begin
        s <= GAIN_ONE[15:0];
      end else begin
        s <= s_rnd[15:0];
      end
    end
  end

endmodule

### hw/rtl/equal_power_crossfade_timeline.sv
// Equal-power crossfade timeline: top level with config registers and pipeline.
// Depends on ecf_pkg and ecf_sine.
`timescale 1ns / 1ps

// One frame query enters per cycle while the output is not stalled, and its
// mix parameters pass through the progress divider, which resolves one quotient
// bit per stage, then the five-stage fade polynomial and the gain scaling
// stage. The whole pipeline holds while the result at the output is not
// taken. Write the configuration only while no query is in flight.
module equal_power_crossfade_timeline #(
  parameter int FRAME_BITS    = ecf_pkg::FRAME_BITS_DEF,
  parameter int PROGRESS_BITS = ecf_pkg::PROGRESS_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [((FRAME_BITS+7)/8)*8-1:0]     s_tdata,   // frame
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // phase, out_gain, in_gain, out_low, out_mid, in_low, in_mid
  output logic [103:0]                        m_tdata,
  input  logic                                cfg_wr,
  input  logic [ecf_pkg::REG_IDX_W-1:0]       cfg_idx,
  input  logic [FRAME_BITS-1:0]               cfg_data
);
  import ecf_pkg::*;

  localparam int PB     = PROGRESS_BITS;
  localparam int XSHIFT = 24 - PB;
  localparam int SL     = 5;
  localparam int SUM_W  = 17 + PB + 2;

  // configuration
  logic [FRAME_BITS-1:0] start_frame;
  logic [DUR_W-1:0]      duration_frames;
  logic [1:0]            mode;
  logic [31:0]           gain_pair;
  logic [31:0]           eq_pair [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      start_frame     <= '0;
      duration_frames <= DUR_W'(1);
      mode            <= '0;
      gain_pair       <= GAIN_PAIR_RST;
      for (int i = 0; i < 4; i++) eq_pair[i] <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx_t'(cfg_idx))
        REG_START:    start_frame     <= cfg_data;
        REG_DURATION: duration_frames <= cfg_data[DUR_W-1:0];
        REG_MODE:     mode            <= cfg_data[1:0];
        REG_GAIN:     gain_pair       <= cfg_data[31:0];
        REG_OUT_LOW:  eq_pair[0]      <= cfg_data[31:0];
        REG_OUT_MID:  eq_pair[1]      <= cfg_data[31:0];
        REG_IN_LOW:   eq_pair[2]      <= cfg_data[31:0];
        REG_IN_MID:   eq_pair[3]      <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en       = !m_tvalid || m_tready;
  // hold off input transfers while in reset
  assign s_tready = en && !rst;

  // classify the frame
  logic [DUR_W-1:0]      dur;
  logic [FRAME_BITS:0]   end_sum;
  logic [FRAME_BITS-1:0] end_frame;
  logic [FRAME_BITS-1:0] frame;
  logic [FRAME_BITS-1:0] offset;
  phase_t                ph_in;

  always_comb begin
    dur       = (duration_frames == '0) ? DUR_W'(1) : duration_frames;
    end_sum   = {1'b0, start_frame} + (FRAME_BITS+1)'(dur);
    // saturate the end frame at the top of the frame range
    end_frame = end_sum[FRAME_BITS] ? '1 : end_sum[FRAME_BITS-1:0];
    frame     = s_tdata[FRAME_BITS-1:0];
    offset    = frame - start_frame;
    if (!mode[0])                  ph_in = PH_OFF;
    else if (frame < start_frame)  ph_in = PH_BEFORE;
    else if (frame >= end_frame)   ph_in = PH_AFTER;
    else                           ph_in = PH_DURING;
  end

  // restoring divider, one quotient bit per stage
  logic             dv   [PB+1];
  phase_t           dph  [PB+1];
  logic [DUR_W-1:0] drem [PB+1];
  logic [PB-1:0]    dq   [PB+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= PB; k++) dv[k] <= 1'b0;
    end else if (en) begin
      dv[0] <= s_tvalid;
      for (int k = 0; k < PB; k++) dv[k+1] <= dv[k];
    end
  end

  always_ff @(posedge clk) begin
    logic [DUR_W:0] r2;
    if (en) begin
      dph[0]  <= ph_in;
      drem[0] <= offset[DUR_W-1:0];
      dq[0]   <= '0;
      for (int k = 0; k < PB; k++) begin
        r2 = {drem[k], 1'b0};
        dph[k+1] <= dph[k];
        if (r2 >= {1'b0, dur}) begin
          drem[k+1] <= DUR_W'(r2 - {1'b0, dur});
          dq[k+1]   <= {dq[k][PB-2:0], 1'b1};
        end else begin
          drem[k+1] <= r2[DUR_W-1:0];
          dq[k+1]   <= {dq[k][PB-2:0], 1'b0};
        end
      end
    end
  end

  // progress: zero before the start, one after the end
  logic [PB:0] p_sel;
  logic [PB:0] p_inv;
  logic [24:0] x_in_fade, x_out_fade;

  always_comb begin
    unique case (dph[PB])
      PH_AFTER:  p_sel = (PB+1)'(1) << PB;
      PH_DURING: p_sel = {1'b0, dq[PB]};
      default:   p_sel = '0;
    endcase
    p_inv      = ((PB+1)'(1) << PB) - p_sel;
    x_in_fade  = 25'(p_sel) << XSHIFT;
    x_out_fade = 25'(p_inv) << XSHIFT;
  end

  logic [15:0] fade_in, fade_out;

  ecf_sine u_sine_in (
    .clk (clk),
    .en  (en),
    .x   (x_in_fade),
    .s   (fade_in)
  );

  ecf_sine u_sine_out (
    .clk (clk),
    .en  (en),
    .x   (x_out_fade),
    .s   (fade_out)
  );

  // side path alongside the fade pipeline; EQ is interpolated in its second stage
  logic        cv  [SL];
  phase_t      cph [SL];
  logic [PB:0] cp  [SL];
  logic [15:0] ceq [SL][4];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < SL; k++) cv[k] <= 1'b0;
    end else if (en) begin
      cv[0] <= dv[PB];
      for (int k = 1; k < SL; k++) cv[k] <= cv[k-1];
    end
  end

  always_ff @(posedge clk) begin
    logic [16:0]      from_v, to_v;
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] rnd;
    if (en) begin
      cph[0] <= dph[PB];
      cp[0]  <= p_sel;
      for (int i = 0; i < 4; i++) ceq[0][i] <= '0;
      for (int k = 1; k < SL; k++) begin
        cph[k] <= cph[k-1];
        cp[k]  <= cp[k-1];
      end
      for (int i = 0; i < 4; i++) begin
        // offset binary keeps the weighted sum unsigned
        from_v = {1'b0, eq_pair[i][15:0] ^ 16'h8000};
        to_v   = {1'b0, eq_pair[i][31:16] ^ 16'h8000};
        sum    = SUM_W'(from_v) * SUM_W'(((PB+1)'(1) << PB) - cp[0])
               + SUM_W'(to_v) * SUM_W'(cp[0]);
        rnd    = (sum + (SUM_W'(1) << (PB - 1))) >> PB;
        ceq[1][i] <= rnd[15:0] ^ 16'h8000;
      end
      for (int k = 2; k < SL; k++) begin
        for (int i = 0; i < 4; i++) ceq[k][i] <= ceq[k-1][i];
      end
    end
  end

  // gain scaling and output register
  logic [31:0] prod_out, prod_in;
  logic [17:0] sg_out, sg_in;
  logic [15:0] lim_out, lim_in, sc_out, sc_in;
  logic [15:0] g_out_o, g_in_o;
  logic [15:0] eq_o [4];

  always_comb begin
    prod_out = 32'(gain_pair[15:0]) * 32'(fade_out);
    prod_in  = 32'(gain_pair[31:16]) * 32'(fade_in);
    sg_out   = 18'((33'(prod_out) + 33'd16384) >> 15);
    sg_in    = 18'((33'(prod_in) + 33'd16384) >> 15);
    lim_out  = (17'(gain_pair[15:0]) > GAIN_ONE) ? GAIN_ONE[15:0] : gain_pair[15:0];
    lim_in   = (17'(gain_pair[31:16]) > GAIN_ONE) ? GAIN_ONE[15:0] : gain_pair[31:16];
    sc_out   = (sg_out > 18'(GAIN_ONE)) ? GAIN_ONE[15:0] : sg_out[15:0];
    sc_in    = (sg_in > 18'(GAIN_ONE)) ? GAIN_ONE[15:0] : sg_in[15:0];
    unique case (cph[SL-1])
      PH_BEFORE: begin
        g_out_o = lim_out;
        g_in_o  = '0;
      end
      PH_AFTER: begin
        g_out_o = '0;
        g_in_o  = lim_in;
      end
      PH_DURING: begin
        g_out_o = mode[1] ? sc_out : lim_out;
        g_in_o  = mode[1] ? sc_in : '0;
      end
      default: begin
        g_out_o = '0;
        g_in_o  = '0;
      end
    endcase
    for (int i = 0; i < 4; i++) begin
      eq_o[i] = (cph[SL-1] == PH_OFF) ? '0 : ceq[SL-1][i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= cv[SL-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {6'b0, eq_o[3], eq_o[2], eq_o[1], eq_o[0], g_in_o, g_out_o,
                  cph[SL-1]};
    end
  end

  a_off_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] == PH_OFF |-> m_tdata[97:2] == '0)
    else $error("unarmed result carries nonzero fields");

  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[17:2] <= GAIN_ONE[15:0] && m_tdata[33:18] <= GAIN_ONE[15:0])
    else $error("gain above unity");

  a_before_in_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] == PH_BEFORE |-> m_tdata[33:18] == '0)
    else $error("incoming gain nonzero before start");

  a_after_out_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] == PH_AFTER |-> m_tdata[17:2] == '0)
    else $error("outgoing gain nonzero after end");

endmodule

### sim/tb_top.sv
// Self-checking testbench for equal_power_crossfade_timeline: directed table, then random.
// Predicts results in SystemVerilog or takes them from the table; checks the output stream field by field.
// Depends on ecf_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_top;
  import ecf_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int HOLD_CYCLES    = 300;
  localparam longint unsigned FRAME_MASK = 64'hFFFF_FFFF_FFFF;
  localparam longint unsigned PROG_ONE   = 64'd65536;

  // m_tdata layout, highest field first
  typedef struct packed {
    logic [5:0]  pad;
    logic [15:0] in_mid;
    logic [15:0] in_low;
    logic [15:0] out_mid;
    logic [15:0] out_low;
    logic [15:0] in_gain;
    logic [15:0] out_gain;
    logic [1:0]  phase;
  } mix_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_FRAME, ROW_CHECKED} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    reg_idx_t    idx;
    logic [47:0] value;   // register data or frame
    mix_t        typed;   // used by ROW_CHECKED rows
  } row_t;

  logic         clk, rst;
  logic         s_tvalid, s_tready;
  logic [47:0]  s_tdata;   // frame
  logic         m_tvalid, m_tready;
  logic [103:0] m_tdata;   // phase, out_gain, in_gain, out_low, out_mid, in_low, in_mid
  logic         cfg_wr;
  reg_idx_t     cfg_idx;
  logic [47:0]  cfg_data;

  equal_power_crossfade_timeline u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_wr(cfg_wr), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  // local copy of the register file
  logic [47:0] start_r;
  logic [31:0] dur_r;
  logic [1:0]  mode_r;
  logic [31:0] gain_r, out_low_r, out_mid_r, in_low_r, in_mid_r;

  mix_t mix_q[$];
  int   errors;
  int   tx_idle, rx_idle;
  bit   hold_req;
  int   stall_cnt;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint unsigned quarter_sine(longint unsigned x);
    longint unsigned y, t, s;
    if (x >= 64'd16777216) return 64'd32768;
    y = (x * x) >> 24;
    t = 64'(SIN_A5) - ((y * 64'(SIN_A7)) >> 24);
    t = 64'(SIN_A3) - ((y * t) >> 24);
    t = 64'(SIN_A1) - ((y * t) >> 24);
    s = (x * t) >> 24;
    s = (s + 64'd16384) >> 15;
    return (s > 64'd32768) ? 64'd32768 : s;
  endfunction

  function automatic logic [15:0] clamp_gain(longint unsigned g);
    return (g > 64'd32768) ? 16'h8000 : g[15:0];
  endfunction

  function automatic logic [15:0] eq_blend(logic [31:0] pair, longint unsigned p);
    longint unsigned from_v, to_v, v;
    from_v = 64'(pair[15:0] ^ 16'h8000);
    to_v   = 64'(pair[31:16] ^ 16'h8000);
    v = (from_v * (PROG_ONE - p) + to_v * p + (PROG_ONE >> 1)) >> 16;
    return v[15:0] ^ 16'h8000;
  endfunction

  function automatic mix_t predict_mix(logic [47:0] frame);
    longint unsigned st, dur, fin, p, go, gi, f;
    mix_t r;
    r   = '0;
    f   = 64'(frame);
    st  = 64'(start_r);
    dur = (dur_r == 0) ? 64'd1 : 64'(dur_r);
    fin = st + dur;
    if (fin < st || fin > FRAME_MASK) fin = FRAME_MASK;
    if (!mode_r[0]) return r;
    go = 64'(gain_r[15:0]);
    gi = 64'(gain_r[31:16]);
    if (f < st) begin
      r.phase    = PH_BEFORE;
      r.out_gain = clamp_gain(go);
      p = 0;
    end else if (f >= fin) begin
      r.phase   = PH_AFTER;
      r.in_gain = clamp_gain(gi);
      p = PROG_ONE;
    end else begin
      p = ((f - st) << 16) / dur;
      r.phase = PH_DURING;
      if (mode_r[1]) begin
        r.out_gain = clamp_gain((go * quarter_sine((PROG_ONE - p) << 8) + 64'd16384) >> 15);
        r.in_gain  = clamp_gain((gi * quarter_sine(p << 8) + 64'd16384) >> 15);
      end else begin
        r.out_gain = clamp_gain(go);
      end
    end
    r.out_low = eq_blend(out_low_r, p);
    r.out_mid = eq_blend(out_mid_r, p);
    r.in_low  = eq_blend(in_low_r, p);
    r.in_mid  = eq_blend(in_mid_r, p);
    return r;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic write_reg(reg_idx_t idx, logic [47:0] value);
    cfg_wr   = 1'b1;
    cfg_idx  = idx;
    cfg_data = value;
    case (idx)
      REG_START:    start_r   = value;
      REG_DURATION: dur_r     = value[31:0];
      REG_MODE:     mode_r    = value[1:0];
      REG_GAIN:     gain_r    = value[31:0];
      REG_OUT_LOW:  out_low_r = value[31:0];
      REG_OUT_MID:  out_mid_r = value[31:0];
      REG_IN_LOW:   in_low_r  = value[31:0];
      REG_IN_MID:   in_mid_r  = value[31:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_wr = 1'b0;
  endtask

  task automatic drain();
    while (mix_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic send_frame(logic [47:0] frame, bit typed, mix_t typed_mix);
    while ($urandom_range(99) < tx_idle) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = frame;
    do @(posedge clk); while (!s_tready);
    mix_q.push_back(typed ? typed_mix : predict_mix(frame));
    @(negedge clk);
  endtask

  function automatic logic [47:0] rand48();
    return 48'({$urandom(), $urandom()});
  endfunction

  task automatic random_setup();
    logic [47:0] st;
    logic [31:0] dur;
    case ($urandom_range(3))
      0: st = 0;
      1: st = 48'($urandom_range(5000));
      2: st = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(5000));
      default: st = rand48();
    endcase
    case ($urandom_range(5))
      0: dur = $urandom_range(1, 4);
      1: dur = $urandom_range(5, 300);
      2: dur = $urandom_range(1000, 100000);
      3: dur = $urandom();
      4: dur = 32'hFFFF_FFFF;
      default: dur = 0;
    endcase
    drain();
    write_reg(REG_START, st);
    write_reg(REG_DURATION, 48'(dur));
    write_reg(REG_MODE, ($urandom_range(7) == 0) ? 48'($urandom_range(3))
                                                 : 48'({$urandom_range(1), 1'b1}));
    write_reg(REG_GAIN, ($urandom_range(2) == 0) ? 48'h8000_8000 : 48'($urandom()));
    write_reg(REG_OUT_LOW, 48'($urandom()));
    write_reg(REG_OUT_MID, 48'($urandom()));
    write_reg(REG_IN_LOW, 48'($urandom()));
    write_reg(REG_IN_MID, 48'($urandom()));
  endtask

  function automatic logic [47:0] pick_frame();
    longint unsigned d, off;
    d = (dur_r == 0) ? 64'd1 : 64'(dur_r);
    case ($urandom_range(9))
      7: return rand48();
      8: return start_r;
      9: return start_r + 48'(d) - 48'($urandom_range(1));
      default: begin
        off = {$urandom(), $urandom()} % (d + d / 4 + 2);
        return 48'(64'(start_r) + off - (d / 8 + 1));
      end
    endcase
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      m_tready = ($urandom_range(99) >= rx_idle);
    end
  end

  // output checker
  always @(posedge clk) begin
    mix_t got, want;
    logic [15:0] g[7], w[7];
    string names[7];
    if (!rst && m_tvalid && m_tready) begin
      got = mix_t'(m_tdata);
      if (mix_q.size() == 0) begin
        $display("%0t: unexpected transfer %h", $time, m_tdata);
        errors++;
      end else begin
        want = mix_q.pop_front();
        names = '{"phase", "out_gain", "in_gain", "out_low", "out_mid", "in_low", "in_mid"};
        g = '{16'(got.phase), got.out_gain, got.in_gain, got.out_low, got.out_mid,
              got.in_low, got.in_mid};
        w = '{16'(want.phase), want.out_gain, want.in_gain, want.out_low, want.out_mid,
              want.in_low, want.in_mid};
        for (int i = 0; i < 7; i++)
          if (g[i] !== w[i]) begin
            $display("%0t: %s expected %h actual %h", $time, names[i], w[i], g[i]);
            errors++;
          end
      end
    end
  end

  // watchdog: cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= WATCHDOG_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  function automatic mix_t mk(logic [1:0] ph, logic [15:0] og, logic [15:0] ig,
                              logic [15:0] ol, logic [15:0] om,
                              logic [15:0] il, logic [15:0] im);
    mix_t r;
    r = '{pad: '0, phase: ph, out_gain: og, in_gain: ig, out_low: ol, out_mid: om,
          in_low: il, in_mid: im};
    return r;
  endfunction

  function automatic row_t frow(logic [47:0] f);
    row_t r;
    r = '{kind: ROW_FRAME, idx: REG_START, value: f, typed: '0};
    return r;
  endfunction

  function automatic row_t crow(reg_idx_t idx, logic [47:0] v);
    row_t r;
    r = '{kind: ROW_CFG, idx: idx, value: v, typed: '0};
    return r;
  endfunction

  function automatic row_t xrow(logic [47:0] f, mix_t m);
    row_t r;
    r = '{kind: ROW_CHECKED, idx: REG_START, value: f, typed: m};
    return r;
  endfunction

  initial begin
    row_t rows[$];
    errors   = 0;
    hold_req = 1'b0;
    tx_idle  = 0;
    rx_idle  = 0;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    cfg_wr   = 1'b0;
    cfg_idx  = REG_START;
    cfg_data = '0;
    start_r = 0; dur_r = 1; mode_r = 0; gain_r = GAIN_PAIR_RST;
    out_low_r = 0; out_mid_r = 0; in_low_r = 0; in_mid_r = 0;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // not armed after reset: everything zero
    rows.push_back(xrow(48'd0, '0));
    rows.push_back(xrow(48'hFFFF_FFFF_FFFF, '0));
    rows.push_back(crow(REG_START, 48'd1000));
    rows.push_back(crow(REG_DURATION, 48'd100));
    rows.push_back(crow(REG_MODE, 48'd3));
    rows.push_back(crow(REG_OUT_LOW, 48'h7FFF_8000));
    rows.push_back(crow(REG_OUT_MID, 48'h8000_7FFF));
    rows.push_back(crow(REG_IN_LOW, 48'h1234_0000));
    rows.push_back(crow(REG_IN_MID, 48'hFFFF_0001));
    rows.push_back(xrow(48'd0, mk(PH_BEFORE, 16'h8000, 0, 16'h8000, 16'h7FFF, 0, 16'h0001)));
    rows.push_back(xrow(48'd999, mk(PH_BEFORE, 16'h8000, 0, 16'h8000, 16'h7FFF, 0, 16'h0001)));
    // frame at start: full outgoing gain, starting EQ
    rows.push_back(xrow(48'd1000, mk(PH_DURING, 16'h8000, 0, 16'h8000, 16'h7FFF, 0, 16'h0001)));
    rows.push_back(frow(48'd1050));
    rows.push_back(frow(48'd1099));
    rows.push_back(xrow(48'd1100, mk(PH_AFTER, 0, 16'h8000, 16'h7FFF, 16'h8000, 16'h1234,
                                     16'hFFFF)));
    rows.push_back(xrow(48'hFFFF_FFFF_FFFF, mk(PH_AFTER, 0, 16'h8000, 16'h7FFF, 16'h8000,
                                               16'h1234, 16'hFFFF)));
    // gapless, and full gains above unity
    rows.push_back(crow(REG_MODE, 48'd1));
    rows.push_back(crow(REG_GAIN, 48'hFFFF_FFFF));
    rows.push_back(frow(48'd1050));
    rows.push_back(xrow(48'd5, mk(PH_BEFORE, 16'h8000, 0, 16'h8000, 16'h7FFF, 0, 16'h0001)));
    // end saturates at the top of the frame range; zero duration
    rows.push_back(crow(REG_MODE, 48'd3));
    rows.push_back(crow(REG_START, 48'hFFFF_FFFF_FF00));
    rows.push_back(crow(REG_DURATION, 48'hFFFF_FFFF));
    rows.push_back(frow(48'hFFFF_FFFF_FF80));
    rows.push_back(frow(48'hFFFF_FFFF_FFFE));
    rows.push_back(frow(48'hFFFF_FFFF_FFFF));
    rows.push_back(crow(REG_START, 48'd7));
    rows.push_back(crow(REG_DURATION, 48'd0));
    rows.push_back(frow(48'd6));
    rows.push_back(frow(48'd7));
    rows.push_back(frow(48'd8));

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        s_tvalid = 1'b0;
        if (i == 0 || rows[i-1].kind != ROW_CFG) drain();
        write_reg(rows[i].idx, rows[i].value);
      end else begin
        send_frame(rows[i].value, rows[i].kind == ROW_CHECKED, rows[i].typed);
      end
    end
    s_tvalid = 1'b0;

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle = (ph == 0) ? 12 : (ph == 1) ? 70 : 0;
      rx_idle = (ph == 0) ? 70 : (ph == 1) ? 12 : 0;
      for (int n = 0; n < 260; n++) begin
        if (n % 40 == 0) begin
          s_tvalid = 1'b0;
          random_setup();
          // fill the pipeline against a stalled output
          if (ph == 2 && n == 40) hold_req = 1'b1;
        end
        send_frame(pick_frame(), 1'b0, '0);
      end
      s_tvalid = 1'b0;
    end

    while (mix_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

endmodule
